[hw/rtl/lfc_pkg.sv]
// lfc_pkg: shared types and constants for the line FIR convolver.
// Used by the channel interfaces and by line_fir_convolver_core.
// No dependencies.
`timescale 1ns / 1ps

package lfc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TAP_INDEX_W = 5;
	localparam int TAP_COUNT_W = 6;
	localparam int SEEN_W      = 6;
	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int FRAC_BITS   = 14;
	localparam int FRAC_MASK   = (1 << FRAC_BITS) - 1;

	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// input item opcodes
	localparam logic FUNC_LOAD_TAP = 1'b0;
	localparam logic FUNC_SAMPLE   = 1'b1;

	// APB register map, decoded on paddr[2]
	localparam int   ADDR_W            = 3;
	localparam int   APB_DATA_W        = 32;
	localparam logic REG_EXPAND_OUTPUT = 1'b0;
	localparam logic REG_TAP_COUNT     = 1'b1;

	localparam logic                   EXPAND_RESET    = 1'b1;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered_sample;
		logic                       end_of_line_out;
	} lfc_out_t;

endpackage

[hw/rtl/lfc_in_if.sv]
// lfc_in_if: input channel of the line FIR convolver (tap loads and samples).
// Depends on lfc_pkg for field widths.
`timescale 1ns / 1ps

interface lfc_in_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic [lfc_pkg::TAP_INDEX_W-1:0]     tap_index;
	logic signed [lfc_pkg::SAMPLE_W-1:0] sample_value;
	logic                                last_in_line;

	modport source (
		output valid, func, tap_index, sample_value, last_in_line,
		input  ready
	);

	modport sink (
		input  valid, func, tap_index, sample_value, last_in_line,
		output ready
	);
endinterface

[hw/rtl/lfc_out_if.sv]
// lfc_out_if: result channel of the line FIR convolver.
// Depends on lfc_pkg for field widths.
`timescale 1ns / 1ps

interface lfc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lfc_pkg::SAMPLE_W-1:0] filtered_sample;
	logic                                end_of_line_out;

	modport source (
		output valid, filtered_sample, end_of_line_out,
		input  ready
	);

	modport sink (
		input  valid, filtered_sample, end_of_line_out,
		output ready
	);
endinterface

[hw/rtl/line_fir_convolver_core.sv]
// line_fir_convolver_core: 1-D FIR over a line of samples, full or same length.
// Depends on lfc_pkg, lfc_in_if and lfc_out_if.
//
// Usage:
//  items   : valid/ready channel. func = 0 writes sample_value into tap tap_index,
//            func = 1 shifts a line sample into the delay line; last_in_line on a
//            sample ends the line.
//  results : valid/ready channel of filtered_sample, end_of_line_out on the last
//            output of each line.
//  APB     : expand_output at 0x0, tap_count at 0x4; pready is tied high.
// Throughput: one item per cycle while items.ready is high. After the last sample of a line the block
//  shifts taps-1 zeros (full mode) or taps/2 zeros (same mode) through the delay
//  line to emit the trailing outputs; items.ready is low then.
// Latency: a result passes the leaf registers of the products, a registered adder
//  tree of clog2(MAX_TAPS) levels and the combinational rounding before it is
//  written into the output FIFO.
// Results land in a small output FIFO; a credit count of outstanding results
//  holds items.ready low only when the FIFO could overflow, so a stalled
//  receiver backs up into the input without losing anything.
// Reset: taps and delay line zero, expand_output = 1, tap_count = 1.
`timescale 1ns / 1ps

module line_fir_convolver_core #(
	parameter int MAX_TAPS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	lfc_in_if.sink                                items,
	lfc_out_if.source                             results,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lfc_pkg::ADDR_W-1:0]            paddr,
	input  logic [lfc_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [lfc_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	localparam int SW    = lfc_pkg::SAMPLE_W;
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int LVL   = $clog2(MAX_TAPS);
	localparam int NP    = 2 ** LVL;
	localparam int NODES = 2 * NP - 1;
	localparam int ACC_W = lfc_pkg::PROD_W + LVL;
	localparam int DEPTH = 2 ** $clog2(LVL + 4);
	localparam int FA    = $clog2(DEPTH);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(lfc_pkg::SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(lfc_pkg::SAMPLE_MIN);

	// configuration
	logic                            expand_q;
	logic [lfc_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic                            cfg_wr;

	// line state
	logic signed [SW-1:0]       tap_q   [0:MAX_TAPS-1];
	logic signed [SW-1:0]       delay_q [0:MAX_TAPS-1];
	logic [lfc_pkg::SEEN_W-1:0] seen_q;
	logic                       flush_q;
	logic                       clr_q;
	logic [CW-1:0]              flush_j_q;
	logic [CW-1:0]              flush_total_q;
	logic [CW-1:0]              flush_thresh_q;

	// datapath
	logic                       emit_s1;
	logic                       eol_s1;
	logic signed [ACC_W-1:0]    node_q [0:NODES-1];
	logic                       vld_q  [0:LVL];
	logic                       eol_q  [0:LVL];
	logic signed [lfc_pkg::PROD_W-1:0] prod [0:MAX_TAPS-1];

	// output queue
	lfc_pkg::lfc_out_t fifo_q [0:DEPTH-1];
	logic [FA:0]       wr_ptr_q;
	logic [FA:0]       rd_ptr_q;
	logic [FA:0]       cnt_q;

	// per-cycle control
	logic                       credit_ok;
	logic                       acc_in;
	logic                       is_sample;
	logic                       is_load;
	logic                       flush_step;
	logic [CW-1:0]              taps;
	logic [CW-1:0]              half_taps;
	logic [CW-1:0]              step_j;
	logic [lfc_pkg::SEEN_W-1:0] line_len;
	logic [CW-1:0]              rem;
	logic [CW-1:0]              new_total;
	logic [CW-1:0]              new_thresh;
	logic                       own_emit;
	logic                       emit_now;
	logic                       eol_now;
	logic                       pop;
	logic                       push;
	logic signed [ACC_W-1:0]    biased;
	logic signed [ACC_W-1:0]    q_full;
	lfc_pkg::lfc_out_t          push_data;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == lfc_pkg::REG_EXPAND_OUTPUT) begin
			prdata[0] = expand_q;
		end else begin
			prdata[lfc_pkg::TAP_COUNT_W-1:0] = tap_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expand_q    <= lfc_pkg::EXPAND_RESET;
			tap_count_q <= lfc_pkg::TAP_COUNT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == lfc_pkg::REG_EXPAND_OUTPUT) begin
				expand_q <= pwdata[0];
			end else begin
				tap_count_q <= pwdata[lfc_pkg::TAP_COUNT_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- control
	always_comb begin
		if (tap_count_q == '0) begin
			taps = CW'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			taps = CW'(MAX_TAPS);
		end else begin
			taps = CW'(tap_count_q);
		end
	end

	assign half_taps = taps >> 1;
	assign credit_ok = cnt_q < (FA + 1)'(DEPTH);
	assign items.ready = !flush_q && credit_ok;
	assign acc_in      = items.valid && items.ready;
	assign is_sample   = acc_in && (items.func == lfc_pkg::FUNC_SAMPLE);
	assign is_load     = acc_in && (items.func == lfc_pkg::FUNC_LOAD_TAP);
	assign flush_step  = flush_q && credit_ok;
	assign step_j      = flush_j_q + CW'(1);

	// trailing outputs of a line: full mode shifts taps-1 zeros, all emitted;
	// same mode shifts taps/2 zeros and emits only the last min(len, taps/2)
	always_comb begin
		line_len = (seen_q == lfc_pkg::SEEN_MAX) ? seen_q : seen_q + 1'b1;
		rem      = (int'(line_len) < int'(half_taps)) ? CW'(line_len) : half_taps;
		if (expand_q) begin
			new_total  = taps - CW'(1);
			new_thresh = CW'(1);
			own_emit   = 1'b1;
		end else begin
			new_total  = half_taps;
			new_thresh = half_taps - rem + CW'(1);
			own_emit   = int'(seen_q) >= int'(half_taps);
		end
		emit_now = (is_sample && own_emit) || (flush_step && step_j >= flush_thresh_q);
		eol_now  = (is_sample && items.last_in_line && new_total == '0) ||
		           (flush_step && step_j == flush_total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= '0;
			flush_q        <= 1'b0;
			clr_q          <= 1'b0;
			flush_j_q      <= '0;
			flush_total_q  <= '0;
			flush_thresh_q <= '0;
			emit_s1        <= 1'b0;
			eol_s1         <= 1'b0;
		end else begin
			emit_s1 <= emit_now;
			eol_s1  <= eol_now;
			clr_q   <= 1'b0;
			if (is_sample) begin
				if (items.last_in_line) begin
					seen_q         <= '0;
					flush_j_q      <= '0;
					flush_total_q  <= new_total;
					flush_thresh_q <= new_thresh;
					if (new_total == '0) begin
						clr_q <= 1'b1;
					end else begin
						flush_q <= 1'b1;
					end
				end else if (seen_q != lfc_pkg::SEEN_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (flush_step) begin
				flush_j_q <= step_j;
				if (step_j == flush_total_q) begin
					flush_q <= 1'b0;
					clr_q   <= 1'b1;
				end
			end
		end
	end

	// tap store and delay line; clr_q wipes the line in the same cycle as its
	// final output is sampled by the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < MAX_TAPS; f++) begin
				tap_q[f]   <= '0;
				delay_q[f] <= '0;
			end
		end else begin
			if (is_load) begin
				for (int f = 0; f < MAX_TAPS; f++) begin
					if (int'(items.tap_index) == f) begin
						tap_q[f] <= items.sample_value;
					end
				end
			end
			if (is_sample || flush_step) begin
				delay_q[0] <= is_sample ? items.sample_value : '0;
				for (int f = 1; f < MAX_TAPS; f++) begin
					delay_q[f] <= clr_q ? '0 : delay_q[f-1];
				end
			end else if (clr_q) begin
				for (int f = 0; f < MAX_TAPS; f++) begin
					delay_q[f] <= '0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- datapath
	always_comb begin
		for (int f = 0; f < MAX_TAPS; f++) begin
			if (f < int'(taps)) begin
				prod[f] = lfc_pkg::PROD_W'(tap_q[f]) * lfc_pkg::PROD_W'(delay_q[f]);
			end else begin
				prod[f] = '0;
			end
		end
	end

	// heap-ordered adder tree: leaves at NP-1.., root at node 0
	always_ff @(posedge clk) begin
		for (int f = 0; f < NP; f++) begin
			if (f < MAX_TAPS) begin
				node_q[NP-1+f] <= ACC_W'(prod[f]);
			end else begin
				node_q[NP-1+f] <= '0;
			end
		end
		for (int k = 0; k < NP - 1; k++) begin
			node_q[k] <= node_q[2*k+1] + node_q[2*k+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LVL; l++) begin
				vld_q[l] <= 1'b0;
				eol_q[l] <= 1'b0;
			end
		end else begin
			vld_q[0] <= emit_s1;
			eol_q[0] <= eol_s1;
			for (int l = 1; l <= LVL; l++) begin
				vld_q[l] <= vld_q[l-1];
				eol_q[l] <= eol_q[l-1];
			end
		end
	end

	// divide by 2^14 toward zero, then clamp to 16 bits
	always_comb begin
		biased = node_q[0][ACC_W-1] ? node_q[0] + ACC_W'(lfc_pkg::FRAC_MASK) : node_q[0];
		q_full = biased >>> lfc_pkg::FRAC_BITS;
		if (q_full > SAT_HI) begin
			push_data.filtered_sample = lfc_pkg::SAMPLE_MAX;
		end else if (q_full < SAT_LO) begin
			push_data.filtered_sample = lfc_pkg::SAMPLE_MIN;
		end else begin
			push_data.filtered_sample = q_full[SW-1:0];
		end
		push_data.end_of_line_out = eol_q[LVL];
	end

	// ---------------------------------------------------------------- output FIFO
	assign push = vld_q[LVL];
	assign pop  = results.valid && results.ready;

	assign results.valid           = wr_ptr_q != rd_ptr_q;
	assign results.filtered_sample = fifo_q[rd_ptr_q[FA-1:0]].filtered_sample;
	assign results.end_of_line_out = fifo_q[rd_ptr_q[FA-1:0]].end_of_line_out;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q[FA-1:0]] <= push_data;
		end
	end

	// cnt_q counts every result from its emission until its transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (emit_now && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!emit_now && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
